// ----- design/srli_pkg.sv -----
// ----------------------------------------------------------------------------
// srli_pkg
// Shared types and constants for the sorted record list insert block.
// ----------------------------------------------------------------------------
package srli_pkg;

    // default list capacity in records
    localparam int SRLI_CAPACITY = 64;

    // insert modes; any other code means insert in key order
    localparam logic [1:0] MODE_FRONT = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;

    // fixed result field widths
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;

    // result status codes
    localparam logic ST_INSERTED = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    // input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] record_key;
        logic [63:0] name_word0;
        logic [63:0] name_word1;
        logic [63:0] name_word2;
        logic [47:0] name_word3;
        logic [31:0] grade_one;
        logic [31:0] grade_two;
        logic [31:0] grade_three;
    } t_in_word;

    // result word
    typedef struct packed {
        logic                 status;
        logic [POS_W-1:0]     position;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 is_full;
        logic                 is_empty;
    } t_out_word;

    // one stored record, key on top
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] name0;
        logic [63:0] name1;
        logic [63:0] name2;
        logic [47:0] name3;
        logic [31:0] grade1;
        logic [31:0] grade2;
        logic [31:0] grade3;
    } t_record;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_next;
        logic scan_stop;
        logic shift_read;
        logic shift_write;
        logic write_new;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic in_ordered;
        logic scan_stop;
        logic shift_done;
        logic out_free;
    } t_stat;

endpackage

// ----- design/srli_if.sv -----
// ----------------------------------------------------------------------------
// srli_in_if / srli_out_if
// Valid/ready channels carrying insert requests and insert results.
// ----------------------------------------------------------------------------
interface srli_in_if import srli_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

interface srli_out_if import srli_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

// ----- design/srli_ram.sv -----
// ----------------------------------------------------------------------------
// srli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- design/srli_ctrl.sv -----
// ----------------------------------------------------------------------------
// srli_ctrl
// Sequencer for one insert: key scan, entry shift, record write, result.
// ----------------------------------------------------------------------------
module srli_ctrl import srli_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SHIFT_RD = 3'd2;
    localparam logic [2:0] S_SHIFT_WR = 3'd3;
    localparam logic [2:0] S_WRITE    = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // take a word only while idle and out of reset
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.full) begin
                        n_state = S_FINISH;
                    end else if (i_stat.in_ordered) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.scan_stop) begin
                    o_cmd.scan_stop = 1'b1;
                    n_state         = S_SHIFT_RD;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_done) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.shift_read = 1'b1;
                    n_state          = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_write = 1'b1;
                n_state           = S_SHIFT_RD;
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- design/srli_dpath.sv -----
// ----------------------------------------------------------------------------
// srli_dpath
// Record store, count, scan/shift index, insert position and result register.
// ----------------------------------------------------------------------------
module srli_dpath import srli_pkg::*; #(
    parameter int CAPACITY = SRLI_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_data,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_word o_out_data
);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int REC_W = $bits(t_record);

    t_record          r_rec;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pos;
    logic             r_reject;
    t_out_word        r_out;
    logic             r_out_valid;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;
    logic [REC_W-1:0] rd_data;
    t_record          rd_rec;
    logic             full;
    logic             front;
    logic             at_end;

    assign rd_rec = t_record'(rd_data);
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign front  = (i_in_data.mode == MODE_FRONT);
    assign at_end = (i_in_data.mode == MODE_END);

    // status to controller
    always_comb begin
        o_stat.full       = full;
        o_stat.in_ordered = !(front || at_end);
        o_stat.scan_stop  = (CNT_W'(r_idx) >= r_count) || !(rd_rec.key < r_rec.key);
        o_stat.shift_done = (r_idx == r_pos);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // memory read address: first key on load, next key on scan, lower entry on shift
    always_comb begin
        rd_en   = i_cmd.load || i_cmd.scan_next || i_cmd.shift_read;
        rd_addr = '0;
        priority if (i_cmd.scan_next) begin
            rd_addr = r_idx + 1'b1;
        end else if (i_cmd.shift_read) begin
            rd_addr = r_idx - 1'b1;
        end
    end

    // memory write: moved entry or new record
    always_comb begin
        wr_en   = i_cmd.shift_write || i_cmd.write_new;
        wr_addr = i_cmd.write_new ? r_pos : r_idx;
        wr_data = i_cmd.write_new ? REC_W'(r_rec) : rd_data;
    end

    srli_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // latch the request and track index and position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rec.key    <= i_in_data.record_key;
            r_rec.name0  <= i_in_data.name_word0;
            r_rec.name1  <= i_in_data.name_word1;
            r_rec.name2  <= i_in_data.name_word2;
            r_rec.name3  <= i_in_data.name_word3;
            r_rec.grade1 <= i_in_data.grade_one;
            r_rec.grade2 <= i_in_data.grade_two;
            r_rec.grade3 <= i_in_data.grade_three;
            r_reject     <= full;
            r_idx        <= (front || at_end) ? IDX_W'(r_count) : '0;
            r_pos        <= front ? '0 : IDX_W'(r_count);
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.scan_stop) begin
            r_pos <= r_idx;
            r_idx <= IDX_W'(r_count);
        end else if (i_cmd.shift_write) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    // count held records
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write_new) begin
            r_count <= r_count + 1'b1;
        end
    end

    // result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.status      <= r_reject ? ST_REJECTED : ST_INSERTED;
            r_out.position    <= r_reject ? '0 : POS_W'(r_pos);
            r_out.entry_count <= CNT_OUT_W'(r_count);
            r_out.is_full     <= full;
            r_out.is_empty    <= (r_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ----- design/sorted_record_list_insert_top.sv -----
// ----------------------------------------------------------------------------
// sorted_record_list_insert_top
// Bounded list of records kept in one RAM, with front, end and ordered insert.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one insert request per word: mode, key, four name words and
//   three grade words. o_out returns exactly one result word per request:
//   status, insert position, count after the insert, full and empty flags.
//   Both channels move a word when valid and ready are high at a clock edge.
//   A request is taken only while the sequencer is idle; the result waits in
//   an output register, so the next request is taken while it is unclaimed.
//   A front or end insert shifts the records at and above the insert position
//   up by one place, writes the new record, then posts the result. A
//   key-order insert first scans keys from the bottom, one key a cycle, and
//   stops at the first key not below the new one or at the end of the list.
//   Each moved record is read and then written back one place higher. A
//   request to a full list is rejected with no scan or shift.
//   Reset empties the list (count to zero) and drops any pending result; RAM
//   contents are not cleared. A stalled receiver holds the result word; the
//   sequencer waits in its final step with the next result until it is taken.
// ----------------------------------------------------------------------------
module sorted_record_list_insert_top import srli_pkg::*; #(
    parameter int CAPACITY = SRLI_CAPACITY
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srli_in_if.snk         i_in,
    srli_out_if.src        o_out
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    // sequencer
    srli_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // record store and result
    srli_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data)
    );
endmodule
